/* hdl/json_string_unescape_decoder_top_defines.svh */
// ----------------------------------------------------------------------------
// JSON string unescape decoder - assertion macros
// Shared property macros for the port checker.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_DECODER_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DECODER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define JSUD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define JSUD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/jsud_pkg.sv */
// ----------------------------------------------------------------------------
// JSON string unescape decoder - package
// Shared types, status codes, character constants and hex digit lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package jsud_pkg;

  typedef logic [7:0] data8_t;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2,
    ST_IDLE = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] byte_count;
    data8_t     byte0;
    data8_t     byte1;
    data8_t     byte2;
    status_t    status;
  } result_t;

  localparam data8_t CH_QUOTE = 8'h22;
  localparam data8_t CH_BSLASH = 8'h5c;
  localparam data8_t CH_SLASH = 8'h2f;
  localparam data8_t CH_SPACE = 8'h20;
  localparam data8_t CH_R = 8'h72;
  localparam data8_t CH_N = 8'h6e;
  localparam data8_t CH_T = 8'h74;
  localparam data8_t CH_B = 8'h62;
  localparam data8_t CH_F = 8'h66;
  localparam data8_t CH_U = 8'h75;

  localparam data8_t CODE_CR = 8'h0d;
  localparam data8_t CODE_LF = 8'h0a;
  localparam data8_t CODE_TAB = 8'h09;
  localparam data8_t CODE_BS = 8'h08;
  localparam data8_t CODE_FF = 8'h0c;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input data8_t c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* hdl/jsud_if.sv */
// ----------------------------------------------------------------------------
// JSON string unescape decoder - channel interfaces
// Valid/ready channels for raw input bytes and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsud_in_if;
  logic               valid;
  logic               ready;
  jsud_pkg::data8_t   in_byte;
  logic               start_req;

  modport source (output valid, output in_byte, output start_req, input ready);
  modport sink   (input valid, input in_byte, input start_req, output ready);
endinterface

interface jsud_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         byte_count;
  jsud_pkg::data8_t   byte0;
  jsud_pkg::data8_t   byte1;
  jsud_pkg::data8_t   byte2;
  jsud_pkg::status_t  status;

  modport source (output valid, output byte_count, output byte0, output byte1,
                  output byte2, output status, input ready);
  modport sink   (input valid, input byte_count, input byte0, input byte1,
                  input byte2, input status, output ready);
endinterface

`default_nettype wire

/* hdl/jsud_decode.sv */
// ----------------------------------------------------------------------------
// JSON string unescape decoder - decode core
// Mode, code point and hex count state plus the per-byte decode logic.
// ----------------------------------------------------------------------------
`default_nettype none

module jsud_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire jsud_pkg::data8_t  c,
  input  wire logic              start,
  output jsud_pkg::result_t      res
);
  import jsud_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_BODY = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_ERR  = 3'd4
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [4:0]  hv;
  logic [15:0] cp_shift;

  assign hv       = hex_value(c);
  assign cp_shift = {cp_r[11:0], hv[3:0]};

  always_comb begin
    mode_nxt    = mode_r;
    cp_nxt      = cp_r;
    hex_cnt_nxt = hex_cnt_r;
    res         = '{byte_count: 2'd0, byte0: 8'h00, byte1: 8'h00, byte2: 8'h00,
                    status: ST_BUSY};
    priority if (start) begin
      cp_nxt      = 16'h0000;
      hex_cnt_nxt = 2'd0;
      if (c == CH_QUOTE) begin
        mode_nxt = MODE_BODY;
      end else begin
        mode_nxt   = MODE_ERR;
        res.status = ST_ERR;
      end
    end else begin
      unique case (mode_r)
        MODE_IDLE: begin
          res.status = ST_IDLE;
        end
        MODE_BODY: begin
          priority if (c == CH_QUOTE) begin
            mode_nxt   = MODE_IDLE;
            res.status = ST_DONE;
          end else if (c == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else if (c < CH_SPACE) begin
            mode_nxt    = MODE_ERR;
            hex_cnt_nxt = 2'd0;
            res.status  = ST_ERR;
          end else begin
            res.byte_count = 2'd1;
            res.byte0      = c;
          end
        end
        MODE_ESC: begin
          mode_nxt       = MODE_BODY;
          res.byte_count = 2'd1;
          unique case (c)
            CH_R:      res.byte0 = CODE_CR;
            CH_N:      res.byte0 = CODE_LF;
            CH_T:      res.byte0 = CODE_TAB;
            CH_B:      res.byte0 = CODE_BS;
            CH_F:      res.byte0 = CODE_FF;
            CH_QUOTE,
            CH_BSLASH,
            CH_SLASH:  res.byte0 = c;
            CH_U: begin
              res.byte_count = 2'd0;
              mode_nxt       = MODE_HEX;
              cp_nxt         = 16'h0000;
              hex_cnt_nxt    = 2'd0;
            end
            default: begin
              res.byte_count = 2'd0;
              mode_nxt       = MODE_ERR;
              hex_cnt_nxt    = 2'd0;
              res.status     = ST_ERR;
            end
          endcase
        end
        MODE_HEX: begin
          if (hv[4]) begin
            mode_nxt    = MODE_ERR;
            hex_cnt_nxt = 2'd0;
            res.status  = ST_ERR;
          end else begin
            cp_nxt = cp_shift;
            if (hex_cnt_r == 2'd3) begin
              hex_cnt_nxt = 2'd0;
              mode_nxt    = MODE_BODY;
              // UTF-8 length from the completed code point
              priority if (cp_shift[15:7] == 9'd0) begin
                res.byte_count = 2'd1;
                res.byte0      = {1'b0, cp_shift[6:0]};
              end else if (cp_shift[15:11] == 5'd0) begin
                res.byte_count = 2'd2;
                res.byte0      = {3'b110, cp_shift[10:6]};
                res.byte1      = {2'b10, cp_shift[5:0]};
              end else begin
                res.byte_count = 2'd3;
                res.byte0      = {4'b1110, cp_shift[15:12]};
                res.byte1      = {2'b10, cp_shift[11:6]};
                res.byte2      = {2'b10, cp_shift[5:0]};
              end
            end else begin
              hex_cnt_nxt = hex_cnt_r + 2'd1;
            end
          end
        end
        default: begin
          mode_nxt   = MODE_ERR;
          res.status = ST_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      cp_r      <= 16'h0000;
      hex_cnt_r <= 2'd0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      cp_r      <= cp_nxt;
      hex_cnt_r <= hex_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/json_string_unescape_decoder_top.sv */
// ----------------------------------------------------------------------------
// JSON string unescape decoder - top level
// Input register, per-byte decode, result register.
//
//   channel  dir  payload                                  handshake
//   in_if    in   in_byte[7:0], start_req                  valid/ready
//   out_if   out  byte_count[1:0], byte0..2[7:0], status   valid/ready
//
// One item per cycle sustained while the result side is not stalled; each item gives exactly one result.
// Items pass through the input register, then are decoded into the result register.
// The decode state advances only when an item moves into the result register.
// Reset (rst_n low, synchronous) empties both registers and returns to idle.
// A stalled result holds; the input register keeps taking items while the
// result register can drain in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_decoder_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  jsud_in_if.sink    in_if,
  jsud_out_if.source out_if
);
  import jsud_pkg::*;

  logic    s1_valid_r;
  data8_t  s1_byte_r;
  logic    s1_start_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t dec_res;
  logic    out_load;
  logic    in_take;

  assign out_load    = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || out_load;
  assign in_take     = in_if.valid && in_if.ready;

  jsud_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (out_load),
    .c     (s1_byte_r),
    .start (s1_start_r),
    .res   (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_if.in_byte;
      s1_start_r <= in_if.start_req;
    end
    if (out_load) begin
      out_res_r <= dec_res;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.byte_count = out_res_r.byte_count;
  assign out_if.byte0      = out_res_r.byte0;
  assign out_if.byte1      = out_res_r.byte1;
  assign out_if.byte2      = out_res_r.byte2;
  assign out_if.status     = out_res_r.status;

endmodule

`default_nettype wire

/* hdl/jsud_checker.sv */
// ----------------------------------------------------------------------------
// JSON string unescape decoder - port checker
// Result consistency and stall checks on the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_string_unescape_decoder_top_defines.svh"

module jsud_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         out_byte_count,
  input wire jsud_pkg::data8_t   out_byte0,
  input wire jsud_pkg::data8_t   out_byte1,
  input wire jsud_pkg::data8_t   out_byte2,
  input wire jsud_pkg::status_t  out_status
);
  import jsud_pkg::*;

  // all byte lanes read as zero when the byte count is zero
  `JSUD_ASSERT_NOW(a_lanes_zero, out_valid && out_byte_count == 2'd0, out_byte0 == 8'h00 && out_byte1 == 8'h00 && out_byte2 == 8'h00, "jsud: byte lane set with zero count")

  // decoded bytes only come with an in-progress status
  `JSUD_ASSERT_NOW(a_bytes_busy, out_valid && out_byte_count != 2'd0, out_status == ST_BUSY, "jsud: bytes with non-busy status")

  // multi-byte results are well-formed UTF-8 lead and continuation bytes
  `JSUD_ASSERT_NOW(a_utf8_form, out_valid && (out_byte_count == 2'd2 || out_byte_count == 2'd3), (out_byte1[7:6] == 2'b10) && ((out_byte_count == 2'd2 && out_byte0[7:5] == 3'b110 && out_byte2 == 8'h00) || (out_byte_count == 2'd3 && out_byte0[7:4] == 4'he && out_byte2[7:6] == 2'b10)), "jsud: malformed UTF-8 sequence")

  // stalled item holds
  `JSUD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_byte_count) && $stable(out_byte0) && $stable(out_byte1) && $stable(out_byte2) && $stable(out_status), "jsud: stalled item changed")

endmodule

bind json_string_unescape_decoder_top jsud_checker u_jsud_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_byte_count (out_if.byte_count),
  .out_byte0      (out_if.byte0),
  .out_byte1      (out_if.byte1),
  .out_byte2      (out_if.byte2),
  .out_status     (out_if.status)
);

`default_nettype wire
